// ===== sv/sdt_pkg.sv =====
// ----------------------------------------------------------------------------
// sdt_pkg
// Shared types for the signed truncating divider: side-band flags that
// travel down the division pipeline next to each operand pair.
// ----------------------------------------------------------------------------
package sdt_pkg;

  typedef struct packed {
    logic neg;   // operand signs differ
    logic zero;  // divisor is zero
  } sdt_flags_t;

endpackage

// ===== sv/signed_divide_truncating_unit.sv =====
// ----------------------------------------------------------------------------
// signed_divide_truncating_unit
// Pipelined signed divider, quotient truncated toward zero. Saturates the
// most negative dividend over minus one and flags division by zero.
// ----------------------------------------------------------------------------
//  channel  | handshake          | payload
//  ---------+--------------------+-------------------------------------------
//  input    | start, busy        | in_numerator, in_denominator
//  result   | out_valid (strobe) | out_quotient, out_overflow, out_div_by_zero
//
//  One beat enters per cycle while busy is low; its result passes one
//  magnitude stage, WIDTH one-bit division stages and a sign stage.
//  Synchronous active-low reset clears all valid bits; busy is high during
//  reset and low otherwise. The receiver cannot stall, so the pipeline
//  never holds.
// ----------------------------------------------------------------------------
module signed_divide_truncating_unit #(
  parameter int WIDTH = 32
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  output logic                    busy,
  input  logic signed [WIDTH-1:0] in_numerator,
  input  logic signed [WIDTH-1:0] in_denominator,
  output logic                    out_valid,
  output logic signed [WIDTH-1:0] out_quotient,
  output logic                    out_overflow,
  output logic                    out_div_by_zero
);

  localparam int Latency = WIDTH + 2;

  logic                busy_r;
  logic                accept;
  logic [WIDTH-1:0]    num_u, den_u;
  logic [WIDTH-1:0]    mag_num_nxt, mag_den_nxt;
  sdt_pkg::sdt_flags_t flags_nxt;

  logic                v0_r;
  logic [WIDTH-1:0]    mag_num_r, mag_den_r;
  sdt_pkg::sdt_flags_t flags0_r;

  logic                v_w     [WIDTH+1];
  logic [WIDTH-1:0]    rem_w   [WIDTH+1];
  logic [WIDTH-1:0]    nq_w    [WIDTH+1];
  logic [WIDTH-1:0]    dvs_w   [WIDTH+1];
  sdt_pkg::sdt_flags_t flags_w [WIDTH+1];

  logic                out_valid_r;
  logic [WIDTH-1:0]    out_quot_r, out_quot_nxt;
  logic                out_ovf_r, out_ovf_nxt;
  logic                out_dbz_r, out_dbz_nxt;
  logic [WIDTH-1:0]    q_fin;
  sdt_pkg::sdt_flags_t f_fin;

  assign accept = start && !busy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b1;
    end else begin
      busy_r <= 1'b0;
    end
  end

  // magnitudes and sign/zero flags
  always_comb begin
    num_u          = WIDTH'(in_numerator);
    den_u          = WIDTH'(in_denominator);
    mag_num_nxt    = num_u[WIDTH-1] ? ({WIDTH{1'b0}} - num_u) : num_u;
    mag_den_nxt    = den_u[WIDTH-1] ? ({WIDTH{1'b0}} - den_u) : den_u;
    flags_nxt.neg  = num_u[WIDTH-1] ^ den_u[WIDTH-1];
    flags_nxt.zero = (den_u == {WIDTH{1'b0}});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
    end else begin
      v0_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    mag_num_r <= mag_num_nxt;
    mag_den_r <= mag_den_nxt;
    flags0_r  <= flags_nxt;
  end

  assign v_w[0]     = v0_r;
  assign rem_w[0]   = {WIDTH{1'b0}};
  assign nq_w[0]    = mag_num_r;
  assign dvs_w[0]   = mag_den_r;
  assign flags_w[0] = flags0_r;

  for (genvar k = 0; k < WIDTH; k++) begin : g_step
    sdt_stage #(.WIDTH(WIDTH)) u_stage (
      .clk     (clk),
      .rst_n   (rst_n),
      .valid_i (v_w[k]),
      .rem_i   (rem_w[k]),
      .nq_i    (nq_w[k]),
      .dvs_i   (dvs_w[k]),
      .flags_i (flags_w[k]),
      .valid_o (v_w[k+1]),
      .rem_o   (rem_w[k+1]),
      .nq_o    (nq_w[k+1]),
      .dvs_o   (dvs_w[k+1]),
      .flags_o (flags_w[k+1])
    );
  end

  // sign fix, saturation and divide-by-zero
  always_comb begin
    q_fin        = nq_w[WIDTH];
    f_fin        = flags_w[WIDTH];
    out_ovf_nxt  = 1'b0;
    out_dbz_nxt  = 1'b0;
    if (f_fin.zero) begin
      out_quot_nxt = {WIDTH{1'b0}};
      out_dbz_nxt  = v_w[WIDTH];
    end else if (f_fin.neg) begin
      out_quot_nxt = {WIDTH{1'b0}} - q_fin;
    end else if (q_fin[WIDTH-1]) begin
      out_quot_nxt = {1'b0, {(WIDTH-1){1'b1}}};
      out_ovf_nxt  = v_w[WIDTH];
    end else begin
      out_quot_nxt = q_fin;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      out_ovf_r   <= 1'b0;
      out_dbz_r   <= 1'b0;
    end else begin
      out_valid_r <= v_w[WIDTH];
      out_ovf_r   <= out_ovf_nxt;
      out_dbz_r   <= out_dbz_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_quot_r <= out_quot_nxt;
  end

  assign busy            = busy_r;
  assign out_valid       = out_valid_r;
  assign out_quotient    = signed'(out_quot_r);
  assign out_overflow    = out_ovf_r;
  assign out_div_by_zero = out_dbz_r;

`ifndef ASSERT_OFF
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, Latency))
    else $error("result strobe without matching input beat");

  a_flags_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (out_overflow || out_div_by_zero) |-> out_valid)
    else $error("status flag raised without a result");

  a_flags_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(out_overflow && out_div_by_zero))
    else $error("overflow and divide-by-zero raised together");

  a_sat_value: assert property (@(posedge clk) disable iff (!rst_n)
    out_overflow |-> (out_quot_r == {1'b0, {(WIDTH-1){1'b1}}}))
    else $error("overflow without saturated quotient");
`endif

endmodule

// ===== sv/sdt_stage.sv =====
// ----------------------------------------------------------------------------
// sdt_stage
// One registered step of restoring division on magnitudes. Shift the top
// dividend bit into the partial remainder, trial-subtract the divisor and
// shift the resulting quotient bit into the low end of the dividend word.
// ----------------------------------------------------------------------------
module sdt_stage #(
  parameter int WIDTH = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               valid_i,
  input  logic [WIDTH-1:0]   rem_i,
  input  logic [WIDTH-1:0]   nq_i,
  input  logic [WIDTH-1:0]   dvs_i,
  input  sdt_pkg::sdt_flags_t flags_i,
  output logic               valid_o,
  output logic [WIDTH-1:0]   rem_o,
  output logic [WIDTH-1:0]   nq_o,
  output logic [WIDTH-1:0]   dvs_o,
  output sdt_pkg::sdt_flags_t flags_o
);

  logic                valid_r;
  logic [WIDTH-1:0]    rem_r, rem_nxt;
  logic [WIDTH-1:0]    nq_r, nq_nxt;
  logic [WIDTH-1:0]    dvs_r;
  sdt_pkg::sdt_flags_t flags_r;
  logic [WIDTH-1:0]    rem_sh;
  logic                fits;

  always_comb begin
    rem_sh  = {rem_i[WIDTH-2:0], nq_i[WIDTH-1]};
    fits    = (rem_sh >= dvs_i);
    rem_nxt = fits ? (rem_sh - dvs_i) : rem_sh;
    nq_nxt  = {nq_i[WIDTH-2:0], fits};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    rem_r   <= rem_nxt;
    nq_r    <= nq_nxt;
    dvs_r   <= dvs_i;
    flags_r <= flags_i;
  end

  assign valid_o = valid_r;
  assign rem_o   = rem_r;
  assign nq_o    = nq_r;
  assign dvs_o   = dvs_r;
  assign flags_o = flags_r;

endmodule
